>>> src/smsq_pkg.sv
package smsq_pkg;

   localparam int CFG_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int COUNT_WIDTH = 16;
   localparam int RAMP_WIDTH = 4;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXCITE_TICKS = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELAY_STEP0 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELAY_STEPS1TO2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELAY_STEPS3TO5 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELAY_STEPS6TO9 = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CRUISE_DELAY = 3'd5;

   localparam logic [CFG_WIDTH-1:0] EXCITE_TICKS_RESET = 24'd1000;
   localparam logic [CFG_WIDTH-1:0] DELAY_RESET = 24'd0;
   localparam logic [CFG_WIDTH-1:0] CRUISE_DELAY_RESET = 24'd1;

   // Last ramp index of each pause band; the index saturates at RAMP_CRUISE.
   localparam logic [RAMP_WIDTH-1:0] RAMP_STEP0_LAST = 4'd0;
   localparam logic [RAMP_WIDTH-1:0] RAMP_BAND1_LAST = 4'd2;
   localparam logic [RAMP_WIDTH-1:0] RAMP_BAND2_LAST = 4'd5;
   localparam logic [RAMP_WIDTH-1:0] RAMP_BAND3_LAST = 4'd9;
   localparam logic [RAMP_WIDTH-1:0] RAMP_CRUISE = 4'd10;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_START = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_START  = 5'b00010,
      ST_EXCITE = 5'b00100,
      ST_PAUSE  = 5'b01000,
      ST_STOP   = 5'b10000
   } stage_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] excite_ticks;
      logic [CFG_WIDTH-1:0] delay_step0;
      logic [CFG_WIDTH-1:0] delay_steps1to2;
      logic [CFG_WIDTH-1:0] delay_steps3to5;
      logic [CFG_WIDTH-1:0] delay_steps6to9;
      logic [CFG_WIDTH-1:0] cruise_delay;
   } cfg_type;

   typedef struct packed {
      logic a_phase;
      logic b_phase;
      logic windings_on;
      logic busy_res;
      logic cmd_rejected;
      logic move_done;
   } result_type;

endpackage

>>> src/smsq_ifs.sv
interface smsq_req_if;
   import smsq_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [COUNT_WIDTH-1:0] step_count;

   modport source (output valid, output req_type, output step_count, input ready);
   modport sink (input valid, input req_type, input step_count, output ready);
endinterface

interface smsq_rsp_if;
   logic valid;
   logic ready;
   logic a_phase;
   logic b_phase;
   logic windings_on;
   logic busy_res;
   logic cmd_rejected;
   logic move_done;

   modport source (output valid, output a_phase, output b_phase, output windings_on,
                   output busy_res, output cmd_rejected, output move_done, input ready);
   modport sink (input valid, input a_phase, input b_phase, input windings_on,
                 input busy_res, input cmd_rejected, input move_done, output ready);
endinterface

interface smsq_csr_if;
   import smsq_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] reg_index;
   logic [CFG_WIDTH-1:0]       wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> src/smsq_csr_regs.sv
module smsq_csr_regs
   import smsq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] wr_index,
   input  logic [CFG_WIDTH-1:0]       wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_EXCITE_TICKS:    cfg_in.excite_ticks = wr_data;
            CSR_DELAY_STEP0:     cfg_in.delay_step0 = wr_data;
            CSR_DELAY_STEPS1TO2: cfg_in.delay_steps1to2 = wr_data;
            CSR_DELAY_STEPS3TO5: cfg_in.delay_steps3to5 = wr_data;
            CSR_DELAY_STEPS6TO9: cfg_in.delay_steps6to9 = wr_data;
            CSR_CRUISE_DELAY:    cfg_in.cruise_delay = wr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.excite_ticks <= EXCITE_TICKS_RESET;
         cfg_ff.delay_step0 <= DELAY_RESET;
         cfg_ff.delay_steps1to2 <= DELAY_RESET;
         cfg_ff.delay_steps3to5 <= DELAY_RESET;
         cfg_ff.delay_steps6to9 <= DELAY_RESET;
         cfg_ff.cruise_delay <= CRUISE_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/smsq_motion_ctrl.sv
module smsq_motion_ctrl
   import smsq_pkg::*;
#(
   parameter int TIMER_BITS = 24
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   req_type,
   input  logic [COUNT_WIDTH-1:0] step_count,
   input  cfg_type                cfg,
   output result_type             result
);

   stage_type              stage_ff, stage_in;
   logic [1:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] steps_left_ff, steps_left_in;
   logic [RAMP_WIDTH-1:0]  ramp_ff, ramp_in;
   logic                   forward_ff, forward_in;
   logic [TIMER_BITS-1:0]  timer_ff, timer_in;

   logic [TIMER_BITS-1:0]  excite_load;
   logic [TIMER_BITS-1:0]  pause_load;
   logic [TIMER_BITS-1:0]  timer_dec;
   logic [CFG_WIDTH-1:0]   pause_sel;
   logic [1:0]             phase_step;
   logic                   rejected;
   logic                   done;

   // Register values are zero-extended or truncated to the timer width.
   function automatic logic [TIMER_BITS-1:0] to_timer(input logic [CFG_WIDTH-1:0] v);
      logic [31:0] wide;
      wide = {{(32 - CFG_WIDTH){1'b0}}, v};
      return wide[TIMER_BITS-1:0];
   endfunction

   always_comb begin
      excite_load = to_timer(cfg.excite_ticks);
      if (excite_load == '0) begin
         excite_load = {{(TIMER_BITS - 1){1'b0}}, 1'b1};
      end

      if (ramp_ff == RAMP_STEP0_LAST) begin
         pause_sel = cfg.delay_step0;
      end else if (ramp_ff <= RAMP_BAND1_LAST) begin
         pause_sel = cfg.delay_steps1to2;
      end else if (ramp_ff <= RAMP_BAND2_LAST) begin
         pause_sel = cfg.delay_steps3to5;
      end else if (ramp_ff <= RAMP_BAND3_LAST) begin
         pause_sel = cfg.delay_steps6to9;
      end else begin
         pause_sel = cfg.cruise_delay;
      end
      pause_load = to_timer(pause_sel);

      // Gray sequence 00,01,11,10 on {b,a}; backward runs it in reverse.
      case ({forward_ff, phase_ff})
         3'b100:  phase_step = 2'b01;
         3'b101:  phase_step = 2'b11;
         3'b111:  phase_step = 2'b10;
         3'b110:  phase_step = 2'b00;
         3'b000:  phase_step = 2'b10;
         3'b010:  phase_step = 2'b11;
         3'b011:  phase_step = 2'b01;
         3'b001:  phase_step = 2'b00;
         default: phase_step = 2'b00;
      endcase

      timer_dec = (timer_ff != '0) ? timer_ff - 1'b1 : timer_ff;
   end

   always_comb begin
      stage_in = stage_ff;
      phase_in = phase_ff;
      steps_left_in = steps_left_ff;
      ramp_in = ramp_ff;
      forward_in = forward_ff;
      timer_in = timer_ff;
      rejected = 1'b0;
      done = 1'b0;

      if (accept) begin
         if (req_type == REQ_START) begin
            if (stage_ff != ST_IDLE) begin
               rejected = 1'b1;
            end else begin
               forward_in = ~step_count[COUNT_WIDTH-1];
               // The magnitude of the most negative count still fits unsigned.
               steps_left_in = step_count[COUNT_WIDTH-1] ? (~step_count + 1'b1) : step_count;
               ramp_in = '0;
               stage_in = ST_START;
               timer_in = excite_load;
            end
         end else if (stage_ff != ST_IDLE) begin
            timer_in = timer_dec;
            if (timer_dec == '0) begin
               case (stage_ff)
                  ST_EXCITE: begin
                     if (ramp_ff < RAMP_CRUISE) begin
                        ramp_in = ramp_ff + 1'b1;
                     end
                     if (steps_left_ff != '0) begin
                        steps_left_in = steps_left_ff - 1'b1;
                     end
                     if (pause_load != '0) begin
                        stage_in = ST_PAUSE;
                        timer_in = pause_load;
                     end else begin
                        timer_in = excite_load;
                        if (steps_left_in != '0) begin
                           phase_in = phase_step;
                           stage_in = ST_EXCITE;
                        end else begin
                           stage_in = ST_STOP;
                        end
                     end
                  end
                  ST_START, ST_PAUSE: begin
                     timer_in = excite_load;
                     if (steps_left_ff != '0) begin
                        phase_in = phase_step;
                        stage_in = ST_EXCITE;
                     end else begin
                        stage_in = ST_STOP;
                     end
                  end
                  ST_STOP: begin
                     stage_in = ST_IDLE;
                     done = 1'b1;
                  end
                  default: stage_in = ST_IDLE;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= ST_IDLE;
         phase_ff <= 2'b00;
         steps_left_ff <= '0;
         ramp_ff <= '0;
         forward_ff <= 1'b1;
         timer_ff <= '0;
      end else begin
         stage_ff <= stage_in;
         phase_ff <= phase_in;
         steps_left_ff <= steps_left_in;
         ramp_ff <= ramp_in;
         forward_ff <= forward_in;
         timer_ff <= timer_in;
      end
   end

   always_comb begin
      result.a_phase = phase_in[0];
      result.b_phase = phase_in[1];
      result.windings_on = (stage_in == ST_START) || (stage_in == ST_EXCITE)
                           || (stage_in == ST_STOP);
      result.busy_res = (stage_in != ST_IDLE);
      result.cmd_rejected = rejected;
      result.move_done = done;
   end

   // An idle sequencer has always run its timer out.
   assert property (@(posedge clock) disable iff (reset)
      stage_ff == ST_IDLE |-> timer_ff == '0)
      else $error("timer not cleared while idle");

   assert property (@(posedge clock) disable iff (reset)
      ramp_ff <= RAMP_CRUISE)
      else $error("ramp index beyond saturation");

   // A move can only begin from an accepted start request.
   assert property (@(posedge clock) disable iff (reset)
      (stage_ff == ST_START) && !$past(stage_ff == ST_START)
      |-> $past(accept && req_type == REQ_START))
      else $error("move started without a start request");

   assert property (@(posedge clock) disable iff (reset)
      done |-> stage_ff == ST_STOP && accept)
      else $error("move done outside the final hold");

endmodule

>>> src/stepper_move_sequencer.sv
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; a new request is taken whenever the
// result register is empty or its result is being taken in the same cycle.
// Reset (synchronous, active high) returns the sequencer to idle with phase 00,
// forward direction, cleared timer and the register defaults 1000,0,0,0,0,1.
module stepper_move_sequencer
   import smsq_pkg::*;
#(
   parameter int TIMER_BITS = 24
)
(
   input logic        clock,
   input logic        reset,
   smsq_req_if.sink   req_chan,
   smsq_rsp_if.source rsp_chan,
   smsq_csr_if.sink   csr_chan
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   smsq_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid),
      .wr_index (csr_chan.reg_index),
      .wr_data  (csr_chan.wr_data),
      .cfg      (cfg)
   );

   smsq_motion_ctrl #(
      .TIMER_BITS (TIMER_BITS)
   ) u_motion_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_type   (req_chan.req_type),
      .step_count (req_chan.step_count),
      .cfg        (cfg),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.a_phase = rsp_data_ff.a_phase;
   assign rsp_chan.b_phase = rsp_data_ff.b_phase;
   assign rsp_chan.windings_on = rsp_data_ff.windings_on;
   assign rsp_chan.busy_res = rsp_data_ff.busy_res;
   assign rsp_chan.cmd_rejected = rsp_data_ff.cmd_rejected;
   assign rsp_chan.move_done = rsp_data_ff.move_done;

   // A result that waits must not be overwritten by a new request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !accept)
      else $error("request accepted over a stalled result");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.move_done |-> !rsp_data_ff.busy_res)
      else $error("move done reported while still busy");

endmodule
